>>> sv/json_string_unescape_defines.svh
// assertion macros used by the checker file
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define JSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("json_string_unescape check failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define JSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("json_string_unescape check failed");

`endif

>>> sv/jsu_pkg.sv
// types, codes and helpers shared by the json string unescape block
`default_nettype none

package jsu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    logic [2:0] error_code;
    logic       last;
  } out_t;

  localparam int unsigned MaxRes = 3;
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoAw = $clog2(FifoDepth);
  localparam int unsigned FifoCw = FifoAw + 1;

  // decoder results for one item
  typedef struct packed {
    logic [1:0]        count;
    out_t [MaxRes-1:0] res;
  } dec_t;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE     = 3'd1;
  localparam logic [2:0] ERR_CONTROL      = 3'd2;
  localparam logic [2:0] ERR_CUT_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_SHORT_HEX    = 3'd4;
  localparam logic [2:0] ERR_BAD_HEX      = 3'd5;
  localparam logic [2:0] ERR_UNKNOWN_ESC  = 3'd6;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd7;

  localparam logic [2:0] MODE_WAIT    = 3'd0;
  localparam logic [2:0] MODE_BODY    = 3'd1;
  localparam logic [2:0] MODE_ESC     = 3'd2;
  localparam logic [2:0] MODE_HEX     = 3'd3;
  localparam logic [2:0] MODE_HEX_BAD = 3'd4;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_CTRL_LIM  = 8'h20;

  // {digit ok, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic out_t mk_res(input logic [7:0] b, input logic valid,
                                  input logic done, input logic [2:0] err);
    out_t r;
    r.out_byte   = b;
    r.byte_valid = valid;
    r.done_res   = done;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/jsu_decode.sv
// decoder state and single-pass unescape of one registered byte
`default_nettype none

module jsu_decode (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         fire_i,
  input  wire jsu_pkg::in_t in_i,
  output jsu_pkg::dec_t     dec_o
);

  logic [2:0]  mode_q, mode_d;
  logic [15:0] cp_q, cp_d;
  logic [1:0]  dc_q, dc_d;

  logic [7:0]  c;
  logic        eoi;
  logic [4:0]  hv;
  logic        bad;
  logic [15:0] v;
  jsu_pkg::dec_t dec;

  assign c   = in_i.in_byte;
  assign eoi = in_i.end_of_input;
  assign hv  = jsu_pkg::hex_digit(c);
  assign bad = (mode_q == jsu_pkg::MODE_HEX_BAD) || !hv[4];
  assign v   = {cp_q[11:0], (hv[4] ? hv[3:0] : 4'd0)};

  always_comb begin
    mode_d = mode_q;
    cp_d   = cp_q;
    dc_d   = dc_q;
    dec    = '0;
    unique case (mode_q)
      jsu_pkg::MODE_BODY: begin
        if (eoi) begin
          mode_d = jsu_pkg::MODE_WAIT;
          cp_d = '0;
          dc_d = '0;
          dec.count = 2'd1;
          dec.res[0] = jsu_pkg::mk_res(8'd0, 1'b0, 1'b0, jsu_pkg::ERR_UNTERMINATED);
        end else if (c == jsu_pkg::CH_QUOTE) begin
          mode_d = jsu_pkg::MODE_WAIT;
          dec.count = 2'd1;
          dec.res[0] = jsu_pkg::mk_res(8'd0, 1'b0, 1'b1, jsu_pkg::ERR_NONE);
        end else if (c < jsu_pkg::CH_CTRL_LIM) begin
          mode_d = jsu_pkg::MODE_WAIT;
          cp_d = '0;
          dc_d = '0;
          dec.count = 2'd1;
          dec.res[0] = jsu_pkg::mk_res(8'd0, 1'b0, 1'b0, jsu_pkg::ERR_CONTROL);
        end else if (c == jsu_pkg::CH_BACKSLASH) begin
          mode_d = jsu_pkg::MODE_ESC;
        end else begin
          dec.count = 2'd1;
          dec.res[0] = jsu_pkg::mk_res(c, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (eoi) begin
          mode_d = jsu_pkg::MODE_WAIT;
          cp_d = '0;
          dc_d = '0;
          dec.count = 2'd1;
          dec.res[0] = jsu_pkg::mk_res(8'd0, 1'b0, 1'b0, jsu_pkg::ERR_CUT_ESCAPE);
        end else begin
          mode_d = jsu_pkg::MODE_BODY;
          dec.count = 2'd1;
          unique case (c)
            8'h22: dec.res[0] = jsu_pkg::mk_res(8'h22, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
            8'h5C: dec.res[0] = jsu_pkg::mk_res(8'h5C, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
            8'h2F: dec.res[0] = jsu_pkg::mk_res(8'h2F, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
            8'h62: dec.res[0] = jsu_pkg::mk_res(8'h08, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
            8'h66: dec.res[0] = jsu_pkg::mk_res(8'h0C, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
            8'h6E: dec.res[0] = jsu_pkg::mk_res(8'h0A, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
            8'h72: dec.res[0] = jsu_pkg::mk_res(8'h0D, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
            8'h74: dec.res[0] = jsu_pkg::mk_res(8'h09, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
            8'h75: begin
              // \u opens a four digit escape
              mode_d = jsu_pkg::MODE_HEX;
              cp_d = '0;
              dc_d = '0;
              dec.count = 2'd0;
            end
            default: begin
              mode_d = jsu_pkg::MODE_WAIT;
              cp_d = '0;
              dc_d = '0;
              dec.res[0] = jsu_pkg::mk_res(8'd0, 1'b0, 1'b0, jsu_pkg::ERR_UNKNOWN_ESC);
            end
          endcase
        end
      end
      jsu_pkg::MODE_HEX, jsu_pkg::MODE_HEX_BAD: begin
        if (eoi) begin
          // a cut escape wins over a bad digit seen earlier
          mode_d = jsu_pkg::MODE_WAIT;
          cp_d = '0;
          dc_d = '0;
          dec.count = 2'd1;
          dec.res[0] = jsu_pkg::mk_res(8'd0, 1'b0, 1'b0, jsu_pkg::ERR_SHORT_HEX);
        end else if (dc_q != 2'd3) begin
          cp_d = v;
          dc_d = dc_q + 2'd1;
          mode_d = bad ? jsu_pkg::MODE_HEX_BAD : jsu_pkg::MODE_HEX;
        end else if (bad) begin
          mode_d = jsu_pkg::MODE_WAIT;
          cp_d = '0;
          dc_d = '0;
          dec.count = 2'd1;
          dec.res[0] = jsu_pkg::mk_res(8'd0, 1'b0, 1'b0, jsu_pkg::ERR_BAD_HEX);
        end else begin
          mode_d = jsu_pkg::MODE_BODY;
          cp_d = '0;
          dc_d = '0;
          // utf-8 encode, surrogates included as plain three byte forms
          if (v < 16'h0080) begin
            dec.count = 2'd1;
            dec.res[0] = jsu_pkg::mk_res(v[7:0], 1'b1, 1'b0, jsu_pkg::ERR_NONE);
          end else if (v < 16'h0800) begin
            dec.count = 2'd2;
            dec.res[0] = jsu_pkg::mk_res({3'b110, v[10:6]}, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
            dec.res[1] = jsu_pkg::mk_res({2'b10, v[5:0]}, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
          end else begin
            dec.count = 2'd3;
            dec.res[0] = jsu_pkg::mk_res({4'b1110, v[15:12]}, 1'b1, 1'b0,
                                         jsu_pkg::ERR_NONE);
            dec.res[1] = jsu_pkg::mk_res({2'b10, v[11:6]}, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
            dec.res[2] = jsu_pkg::mk_res({2'b10, v[5:0]}, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
          end
        end
      end
      default: begin
        // waiting, unused codes too
        if (eoi || c != jsu_pkg::CH_QUOTE) begin
          mode_d = jsu_pkg::MODE_WAIT;
          cp_d = '0;
          dc_d = '0;
          dec.count = 2'd1;
          dec.res[0] = jsu_pkg::mk_res(8'd0, 1'b0, 1'b0, jsu_pkg::ERR_NO_QUOTE);
        end else begin
          mode_d = jsu_pkg::MODE_BODY;
        end
      end
    endcase
    if (dec.count != 2'd0) begin
      dec.res[dec.count - 2'd1].last = 1'b1;
    end
  end

  assign dec_o = dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_WAIT;
      cp_q   <= '0;
      dc_q   <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      cp_q   <= cp_d;
      dc_q   <= dc_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/jsu_res_fifo.sv
// result queue: up to three writes per cycle, one read per cycle
`default_nettype none

module jsu_res_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire jsu_pkg::dec_t dec_i,
  input  wire logic          pop_i,
  output logic               space_o,
  output logic               valid_o,
  output jsu_pkg::out_t      data_o
);

  jsu_pkg::out_t mem_q [jsu_pkg::FifoDepth];
  logic [jsu_pkg::FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [jsu_pkg::FifoCw-1:0] count_q, count_d;
  logic [1:0] n_push;
  logic       do_pop;

  assign n_push  = push_i ? dec_i.count : 2'd0;
  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];
  // room for a full burst without counting this cycle's read
  assign space_o = (count_q <= jsu_pkg::FifoCw'(jsu_pkg::FifoDepth - jsu_pkg::MaxRes));
  assign count_d = count_q + jsu_pkg::FifoCw'(n_push) - jsu_pkg::FifoCw'(do_pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < jsu_pkg::MaxRes; i++) begin
      if (2'(i) < n_push) begin
        mem_q[wr_ptr_q + jsu_pkg::FifoAw'(i)] <= dec_i.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + jsu_pkg::FifoAw'(n_push);
      rd_ptr_q <= rd_ptr_q + jsu_pkg::FifoAw'(do_pop);
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/json_string_unescape.sv
// top level of the streaming json string unescape block
//
// Decodes one quoted json string fed one raw byte per transfer, starting
// with the opening quote, and delivers the decoded bytes, a done mark or an
// error code as result transfers, zero to three per input transfer, the
// final one flagged by last. Escapes \" \\ \/ \b \f \n \r \t are resolved,
// \uXXXX becomes one to three utf-8 bytes (surrogates are not paired).
// After done or any error the block waits for a new opening quote.
// Rate: one input transfer per cycle while the input does not stall; a byte
// is registered, decoded in one pass once the queue has room for its burst
// and written into an eight-entry result queue, from which the first result
// of an item is offered as soon as it has been written.
// Results leave at one per cycle unless the output stalls. The input stalls
// while the queue holds over five results and cannot take a full three-byte
// burst, which a \u escape producing three bytes after six input bytes never
// causes under a free-flowing output. No clearing pass after reset.
`default_nettype none

module json_string_unescape (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire jsu_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output jsu_pkg::out_t      out_data_o
);

  // input register
  logic         in_valid_q;
  jsu_pkg::in_t in_q;

  logic          space;
  logic          fire;
  jsu_pkg::dec_t dec;

  // the registered byte is decoded once the queue can take its burst
  assign fire       = in_valid_q && space;
  assign in_stall_o = in_valid_q && !space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .in_i   (in_q),
    .dec_o  (dec)
  );

  jsu_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .dec_i   (dec),
    .pop_i   (!out_stall_i),
    .space_o (space),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> sv/jsu_checker.sv
// port-level checks for the json string unescape block, bound to the top
`default_nettype none
`include "json_string_unescape_defines.svh"

module jsu_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire jsu_pkg::out_t out_data_o
);

  logic byte_clean;
  logic is_mark;
  logic mark_clean;

  assign byte_clean = !out_data_o.done_res && (out_data_o.error_code == jsu_pkg::ERR_NONE);
  assign is_mark    = out_data_o.done_res || (out_data_o.error_code != jsu_pkg::ERR_NONE);
  assign mark_clean = out_data_o.last && !out_data_o.byte_valid &&
                      (out_data_o.out_byte == 8'd0);

  // a stalled result holds
  `JSU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // a decoded byte never carries done or an error
  `JSU_ASSERT_NOW(a_byte_alone, out_valid_o && out_data_o.byte_valid, byte_clean)

  // errors and done end the item's results and carry no byte
  `JSU_ASSERT_NOW(a_end_mark, out_valid_o && is_mark, mark_clean)

  // nothing leaves straight out of reset
  `JSU_ASSERT_NOW(a_reset_empty, $rose(rst_ni), !out_valid_o)

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
